// File: rtl/bqc_pkg.sv
package bqc_pkg;

  // Block geometry
  localparam int NUM_STAGES  = 4;
  localparam int NUM_PRESETS = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int COEFS       = 5;
  localparam int STAGE_W     = 2;
  localparam int SET_W       = 3;
  localparam int DATA_W      = 16;
  localparam int DLY_N       = 2 * NUM_STAGES;
  localparam int DLY_W       = 3;
  localparam int PC_W        = 4;

  // Number formats: Q2.30 coefficients, Q24.24 signals
  localparam int CW      = 32;
  localparam int QW      = 48;
  localparam int FRAC    = 24;
  localparam int CFRAC   = 30;
  localparam int PL_W    = CW + FRAC + 1;
  localparam int PH_W    = CW + QW - FRAC;
  localparam int FULL_W  = CW + QW;
  localparam int PROD_W  = FULL_W - CFRAC;
  localparam int ACC_W   = 52;

  // Coefficient selector within one stage
  typedef enum logic [2:0] {
    CF_B0 = 3'd0,
    CF_B1 = 3'd1,
    CF_B2 = 3'd2,
    CF_A1 = 3'd3,
    CF_A2 = 3'd4
  } coef_sel_t;

  // Multiplier operand
  typedef enum logic {
    OPD_X = 1'b0,
    OPD_Y = 1'b1
  } opd_t;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_PD   = 2'd1,  // acc = product + delay
    ACC_P    = 2'd2,  // acc = product
    ACC_AP   = 2'd3   // acc = acc + product
  } acc_op_t;

  // Writeback of the saturated accumulator
  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_Y    = 3'd1,
    WB_D1   = 3'd2,
    WB_D2   = 3'd3,
    WB_X    = 3'd4   // x takes y, no accumulator involved
  } wb_t;

  // Sequencer operation
  typedef enum logic [2:0] {
    SEQ_NEXT    = 3'd0,
    SEQ_WAIT_IN = 3'd1,
    SEQ_LOOP    = 3'd2,
    SEQ_EMIT    = 3'd3,
    SEQ_GOTO    = 3'd4
  } seq_op_t;

  // One microcode word
  typedef struct packed {
    seq_op_t           seq;
    logic [PC_W-1:0]   jmp;
    coef_sel_t         coef;
    opd_t              opd;
    acc_op_t           acc_op;
    logic              d_sel;
    wb_t               wb;
  } uword_t;

  // Datapath control, sequencer to datapath
  typedef struct packed {
    coef_sel_t         coef;
    opd_t              opd;
    acc_op_t           acc_op;
    logic              d_sel;
    wb_t               wb;
    logic [STAGE_W-1:0] stage;
    logic              load_x;
  } dp_ctrl_t;

  // Decimal scaling of the coefficient ROM words
  localparam longint Q30 = 64'sd1073741824;
  localparam longint D7  = 64'sd10000000;
  localparam longint D8  = 64'sd100000000;
  localparam longint D9  = 64'sd1000000000;
  localparam longint D10 = 64'sd10000000000;
  localparam longint D11 = 64'sd100000000000;
  localparam longint D12 = 64'sd1000000000000;
  localparam longint D13 = 64'sd10000000000000;
  localparam longint H7  = D7 / 2;
  localparam longint H8  = D8 / 2;
  localparam longint H9  = D9 / 2;
  localparam longint H10 = D10 / 2;
  localparam longint H11 = D11 / 2;
  localparam longint H12 = D12 / 2;
  localparam longint H13 = D13 / 2;

  // Q2.30 coefficients [preset][stage][b0 b1 b2 a1 a2], rounded half away from zero
  localparam logic signed [CW-1:0] COEF_ROM [NUM_PRESETS][NUM_STAGES][COEFS] = '{
    '{ // 0.4 Hz
      '{CW'((15783620 * Q30 + H13) / D13), CW'((31567240 * Q30 + H13) / D13),
        CW'((15783620 * Q30 + H13) / D13), CW'((19990135 * Q30 + H7) / D7),
        CW'(-((99901985 * Q30 + H8) / D8))},
      '{CW'((15769340 * Q30 + H13) / D13), CW'((31538680 * Q30 + H13) / D13),
        CW'((15769340 * Q30 + H13) / D13), CW'((19972050 * Q30 + H7) / D7),
        CW'(-((99721130 * Q30 + H8) / D8))},
      '{CW'((15758428 * Q30 + H13) / D13), CW'((31516856 * Q30 + H13) / D13),
        CW'((15758428 * Q30 + H13) / D13), CW'((19958230 * Q30 + H7) / D7),
        CW'(-((99582930 * Q30 + H8) / D8))},
      '{CW'((15752529 * Q30 + H13) / D13), CW'((31505058 * Q30 + H13) / D13),
        CW'((15752529 * Q30 + H13) / D13), CW'((19950759 * Q30 + H7) / D7),
        CW'(-((99508216 * Q30 + H8) / D8))}
    },
    '{ // 2 Hz
      '{CW'((39381354 * Q30 + H12) / D12), CW'((78762708 * Q30 + H12) / D12),
        CW'((39381354 * Q30 + H12) / D12), CW'((19949514 * Q30 + H7) / D7),
        CW'(-((99510896 * Q30 + H8) / D8))},
      '{CW'((39204201 * Q30 + H12) / D12), CW'((78408402 * Q30 + H12) / D12),
        CW'((39204201 * Q30 + H12) / D12), CW'((19859773 * Q30 + H7) / D7),
        CW'(-((98613417 * Q30 + H8) / D8))},
      '{CW'((39069687 * Q30 + H12) / D12), CW'((78139374 * Q30 + H12) / D12),
        CW'((39069687 * Q30 + H12) / D12), CW'((19791632 * Q30 + H7) / D7),
        CW'(-((97931951 * Q30 + H8) / D8))},
      '{CW'((38997273 * Q30 + H12) / D12), CW'((77994546 * Q30 + H12) / D12),
        CW'((38997273 * Q30 + H12) / D12), CW'((19754949 * Q30 + H7) / D7),
        CW'(-((97565092 * Q30 + H8) / D8))}
    },
    '{ // 4 Hz
      '{CW'((15713498 * Q30 + H11) / D11), CW'((31426996 * Q30 + H11) / D11),
        CW'((15713498 * Q30 + H11) / D11), CW'((19896140 * Q30 + H7) / D7),
        CW'(-((99024256 * Q30 + H8) / D8))},
      '{CW'((15573111 * Q30 + H11) / D11), CW'((31146223 * Q30 + H11) / D11),
        CW'((15573111 * Q30 + H11) / D11), CW'((19718385 * Q30 + H7) / D7),
        CW'(-((97246141 * Q30 + H8) / D8))},
      '{CW'((15467347 * Q30 + H11) / D11), CW'((30934694 * Q30 + H11) / D11),
        CW'((15467347 * Q30 + H11) / D11), CW'((19584468 * Q30 + H7) / D7),
        CW'(-((95906550 * Q30 + H8) / D8))},
      '{CW'((15410705 * Q30 + H11) / D11), CW'((30821409 * Q30 + H11) / D11),
        CW'((15410705 * Q30 + H11) / D11), CW'((19512749 * Q30 + H7) / D7),
        CW'(-((95189129 * Q30 + H8) / D8))}
    },
    '{ // 10 Hz
      '{CW'((97469593 * Q30 + H11) / D11), CW'((19493919 * Q30 + H10) / D10),
        CW'((97469593 * Q30 + H11) / D11), CW'((19718981 * Q30 + H7) / D7),
        CW'(-((97579684 * Q30 + H8) / D8))},
      '{CW'((95337764 * Q30 + H11) / D11), CW'((19067553 * Q30 + H10) / D10),
        CW'((95337764 * Q30 + H11) / D11), CW'((19287692 * Q30 + H7) / D7),
        CW'(-((93258273 * Q30 + H8) / D8))},
      '{CW'((93768096 * Q30 + H11) / D11), CW'((18753619 * Q30 + H10) / D10),
        CW'((93768096 * Q30 + H11) / D11), CW'((18970134 * Q30 + H7) / D7),
        CW'(-((90076413 * Q30 + H8) / D8))},
      '{CW'((92939962 * Q30 + H11) / D11), CW'((18587992 * Q30 + H10) / D10),
        CW'((92939962 * Q30 + H11) / D11), CW'((18802595 * Q30 + H7) / D7),
        CW'(-((88397712 * Q30 + H8) / D8))}
    },
    '{ // 40 Hz
      '{CW'((14981559 * Q30 + H9) / D9), CW'((29963119 * Q30 + H9) / D9),
        CW'((14981559 * Q30 + H9) / D9), CW'((18475297 * Q30 + H7) / D7),
        CW'(-((90745598 * Q30 + H8) / D8))},
      '{CW'((13801535 * Q30 + H9) / D9), CW'((27603069 * Q30 + H9) / D9),
        CW'((13801535 * Q30 + H9) / D9), CW'((17020088 * Q30 + H7) / D7),
        CW'(-((75721493 * Q30 + H8) / D8))},
      '{CW'((13016825 * Q30 + H9) / D9), CW'((26033650 * Q30 + H9) / D9),
        CW'((13016825 * Q30 + H9) / D9), CW'((16052382 * Q30 + H7) / D7),
        CW'(-((65730554 * Q30 + H8) / D8))},
      '{CW'((12628246 * Q30 + H9) / D9), CW'((25256493 * Q30 + H9) / D9),
        CW'((12628246 * Q30 + H9) / D9), CW'((15573186 * Q30 + H7) / D7),
        CW'(-((60783158 * Q30 + H8) / D8))}
    },
    '{ // 100 Hz
      '{CW'((85667865 * Q30 + H9) / D9), CW'((17133573 * Q30 + H8) / D8),
        CW'((85667865 * Q30 + H9) / D9), CW'((14515796 * Q30 + H7) / D7),
        CW'(-((79425105 * Q30 + H8) / D8))},
      '{CW'((71984525 * Q30 + H9) / D9), CW'((14396905 * Q30 + H8) / D8),
        CW'((71984525 * Q30 + H9) / D9), CW'((12197254 * Q30 + H7) / D7),
        CW'(-((50766347 * Q30 + H8) / D8))},
      '{CW'((64143120 * Q30 + H9) / D9), CW'((12828624 * Q30 + H8) / D8),
        CW'((64143120 * Q30 + H9) / D9), CW'((10868585 * Q30 + H7) / D7),
        CW'(-((34343094 * Q30 + H8) / D8))},
      '{CW'((60572179 * Q30 + H9) / D9), CW'((12114436 * Q30 + H8) / D8),
        CW'((60572179 * Q30 + H9) / D9), CW'((10263515 * Q30 + H7) / D7),
        CW'(-((26864019 * Q30 + H8) / D8))}
    },
    '{ // 200 Hz
      '{CW'((29142074 * Q30 + H8) / D8), CW'((58284148 * Q30 + H8) / D8),
        CW'((29142074 * Q30 + H8) / D8), CW'((52130927 * Q30 + H8) / D8),
        CW'(-((68699222 * Q30 + H8) / D8))},
      '{CW'((22605098 * Q30 + H8) / D8), CW'((45210196 * Q30 + H8) / D8),
        CW'((22605098 * Q30 + H8) / D8), CW'((40437229 * Q30 + H8) / D8),
        CW'(-((30857621 * Q30 + H8) / D8))},
      '{CW'((19292853 * Q30 + H8) / D8), CW'((38585705 * Q30 + H8) / D8),
        CW'((19292853 * Q30 + H8) / D8), CW'((34512104 * Q30 + H8) / D8),
        CW'(-((11683514 * Q30 + H8) / D8))},
      '{CW'((17875346 * Q30 + H8) / D8), CW'((35750691 * Q30 + H8) / D8),
        CW'((17875346 * Q30 + H8) / D8), CW'((31976390 * Q30 + H8) / D8),
        CW'(-((34777725 * Q30 + H9) / D9))}
    },
    '{ // 400 Hz
      '{CW'((81145766 * Q30 + H8) / D8), CW'((16229153 * Q30 + H7) / D7),
        CW'((81145766 * Q30 + H8) / D8), CW'(-((14515796 * Q30 + H7) / D7)),
        CW'(-((79425105 * Q30 + H8) / D8))},
      '{CW'((68184721 * Q30 + H8) / D8), CW'((13636944 * Q30 + H7) / D7),
        CW'((68184721 * Q30 + H8) / D8), CW'(-((12197254 * Q30 + H7) / D7)),
        CW'(-((50766347 * Q30 + H8) / D8))},
      '{CW'((60757235 * Q30 + H8) / D8), CW'((12151447 * Q30 + H7) / D7),
        CW'((60757235 * Q30 + H8) / D8), CW'(-((10868585 * Q30 + H7) / D7)),
        CW'(-((34343094 * Q30 + H8) / D8))},
      '{CW'((57374792 * Q30 + H8) / D8), CW'((11474958 * Q30 + H7) / D7),
        CW'((57374792 * Q30 + H8) / D8), CW'(-((10263515 * Q30 + H7) / D7)),
        CW'(-((26864019 * Q30 + H8) / D8))}
    }
  };

endpackage

// File: rtl/bqc_dp.sv
module bqc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bqc_pkg::dp_ctrl_t             ctrl,
  input  logic [bqc_pkg::SET_W-1:0]     preset,
  input  logic                          clear,
  input  logic [bqc_pkg::DATA_W-1:0]    sample,
  output logic [bqc_pkg::DATA_W-1:0]    result
);
  import bqc_pkg::*;

  localparam logic signed [QW-1:0] Q48_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q48_MIN = {1'b1, {(QW-1){1'b0}}};

  logic signed [QW-1:0]     x;
  logic signed [QW-1:0]     y;
  logic signed [QW-1:0]     delays [DLY_N];
  logic signed [CW-1:0]     c_q;
  logic signed [QW-1:0]     v_q;
  logic signed [FRAC:0]     lo_op;
  logic signed [QW-FRAC-1:0] hi_op;
  logic signed [PL_W-1:0]   pl;
  logic signed [PH_W-1:0]   ph;
  logic signed [FULL_W-1:0] full;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [QW-1:0]     sat_val;
  logic signed [QW-1:0]     d_rd;
  logic [DLY_W-1:0]         dly_idx;
  logic [QW-FRAC-1:0]       y_int;

  // Operand issue: coefficient lookup and signal select, registered
  always_ff @(posedge clk) begin
    c_q <= COEF_ROM[preset][ctrl.stage][ctrl.coef];
    v_q <= (ctrl.opd == OPD_Y) ? y : x;
  end

  // Split multiply: low 24 bits unsigned, high 24 bits signed
  assign lo_op = signed'({1'b0, v_q[FRAC-1:0]});
  assign hi_op = v_q[QW-1:FRAC];

  always_ff @(posedge clk) begin
    pl <= c_q * lo_op;
    ph <= c_q * hi_op;
  end

  // Recombine and floor to Q24.24
  assign full = signed'({ph, {FRAC{1'b0}}}) + signed'({{(FULL_W-PL_W){pl[PL_W-1]}}, pl});

  always_ff @(posedge clk) begin
    prod <= full[FULL_W-1:CFRAC];
  end

  // Delay read port
  assign dly_idx = {ctrl.stage, ctrl.d_sel};
  assign d_rd    = delays[dly_idx];

  // Accumulator
  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_PD:  acc <= ACC_W'(prod) + ACC_W'(d_rd);
      ACC_P:   acc <= ACC_W'(prod);
      ACC_AP:  acc <= acc + ACC_W'(prod);
      default: acc <= acc;
    endcase
  end

  // Saturate accumulator to signed 48 bits
  always_comb begin
    if (acc[ACC_W-1] && !(&acc[ACC_W-2:QW-1])) begin
      sat_val = Q48_MIN;
    end else if (!acc[ACC_W-1] && (|acc[ACC_W-2:QW-1])) begin
      sat_val = Q48_MAX;
    end else begin
      sat_val = acc[QW-1:0];
    end
  end

  // Signal registers
  always_ff @(posedge clk) begin
    if (ctrl.load_x) begin
      x <= signed'({{(QW-SAMPLE_BITS-FRAC){1'b0}}, sample, {FRAC{1'b0}}});
    end else if (ctrl.wb == WB_X) begin
      x <= y;
    end
    if (ctrl.wb == WB_Y) begin
      y <= sat_val;
    end
  end

  // Delay states, cleared on reset and on preset write
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < DLY_N; i++) begin
        delays[i] <= '0;
      end
    end else begin
      case (ctrl.wb)
        WB_D1:   delays[{ctrl.stage, 1'b0}] <= sat_val;
        WB_D2:   delays[{ctrl.stage, 1'b1}] <= sat_val;
        default: ;
      endcase
    end
  end

  // Output: truncate to integer, clamp to 0 .. 65535
  assign y_int = y[QW-1:FRAC];

  always_comb begin
    if (y[QW-1]) begin
      result = '0;
    end else if (|y_int[QW-FRAC-1:DATA_W]) begin
      result = '1;
    end else begin
      result = y_int[DATA_W-1:0];
    end
  end

endmodule

// File: rtl/bqc_seq.sv
module bqc_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  output logic              emit,
  output bqc_pkg::dp_ctrl_t ctrl
);
  import bqc_pkg::*;

  localparam int PC_DEPTH = 1 << PC_W;
  localparam logic [PC_W-1:0] PC_IDLE = PC_W'(0);
  localparam logic [PC_W-1:0] PC_BODY = PC_W'(1);
  localparam logic [PC_W-1:0] PC_EMIT = PC_W'(13);

  // Program: one stage body (12 steps) looped over the stages.
  // An issued product passes the operand, partial and product registers to the accumulator input.
  localparam uword_t UCODE [PC_DEPTH] = '{
    '{SEQ_WAIT_IN, PC_IDLE, CF_B0, OPD_X, ACC_HOLD, 1'b0, WB_NONE}, // wait for sample
    '{SEQ_NEXT,    PC_IDLE, CF_B0, OPD_X, ACC_HOLD, 1'b0, WB_NONE}, // issue b0*x
    '{SEQ_NEXT,    PC_IDLE, CF_B1, OPD_X, ACC_HOLD, 1'b0, WB_NONE}, // issue b1*x
    '{SEQ_NEXT,    PC_IDLE, CF_B0, OPD_X, ACC_HOLD, 1'b0, WB_NONE},
    '{SEQ_NEXT,    PC_IDLE, CF_B0, OPD_X, ACC_PD,   1'b0, WB_NONE}, // b0*x + d1
    '{SEQ_NEXT,    PC_IDLE, CF_B0, OPD_X, ACC_PD,   1'b1, WB_Y},    // y; b1*x + d2
    '{SEQ_NEXT,    PC_IDLE, CF_A1, OPD_Y, ACC_HOLD, 1'b0, WB_NONE}, // issue a1*y
    '{SEQ_NEXT,    PC_IDLE, CF_B2, OPD_X, ACC_HOLD, 1'b0, WB_NONE}, // issue b2*x
    '{SEQ_NEXT,    PC_IDLE, CF_A2, OPD_Y, ACC_HOLD, 1'b0, WB_X},    // issue a2*y; x = y
    '{SEQ_NEXT,    PC_IDLE, CF_B0, OPD_X, ACC_AP,   1'b0, WB_NONE}, // + a1*y
    '{SEQ_NEXT,    PC_IDLE, CF_B0, OPD_X, ACC_P,    1'b0, WB_D1},   // new d1; b2*x
    '{SEQ_NEXT,    PC_IDLE, CF_B0, OPD_X, ACC_AP,   1'b0, WB_NONE}, // + a2*y
    '{SEQ_LOOP,    PC_BODY, CF_B0, OPD_X, ACC_HOLD, 1'b0, WB_D2},   // new d2; next stage
    '{SEQ_EMIT,    PC_IDLE, CF_B0, OPD_X, ACC_HOLD, 1'b0, WB_NONE}, // hand off result
    '{SEQ_GOTO,    PC_IDLE, CF_B0, OPD_X, ACC_HOLD, 1'b0, WB_NONE},
    '{SEQ_GOTO,    PC_IDLE, CF_B0, OPD_X, ACC_HOLD, 1'b0, WB_NONE}
  };

  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    pc_next;
  logic [STAGE_W-1:0] stage;
  logic [STAGE_W-1:0] stage_next;
  uword_t             uw;

  assign uw = UCODE[pc];

  // Step counter and jumps
  always_comb begin
    pc_next    = pc;
    stage_next = stage;
    in_ready   = 1'b0;
    emit       = 1'b0;
    case (uw.seq)
      SEQ_WAIT_IN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pc_next    = pc + 1'b1;
          stage_next = '0;
        end
      end
      SEQ_NEXT: pc_next = pc + 1'b1;
      SEQ_LOOP: begin
        if (stage == STAGE_W'(NUM_STAGES - 1)) begin
          pc_next = pc + 1'b1;
        end else begin
          stage_next = stage + 1'b1;
          pc_next    = uw.jmp;
        end
      end
      SEQ_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          pc_next = uw.jmp;
        end
      end
      SEQ_GOTO: pc_next = uw.jmp;
      default:  pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= PC_IDLE;
      stage <= '0;
    end else begin
      pc    <= pc_next;
      stage <= stage_next;
    end
  end

  // Datapath control
  always_comb begin
    ctrl.coef   = uw.coef;
    ctrl.opd    = uw.opd;
    ctrl.acc_op = uw.acc_op;
    ctrl.d_sel  = uw.d_sel;
    ctrl.wb     = uw.wb;
    ctrl.stage  = stage;
    ctrl.load_x = in_valid && in_ready;
  end

`ifndef SYNTH
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(stage) |-> $past(uw.seq == SEQ_LOOP || (uw.seq == SEQ_WAIT_IN && in_valid)))
    else $error("stage counter changed outside a loop step or sample accept");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (rst)
    emit |=> pc == PC_IDLE)
    else $error("sequencer did not return to idle after emitting a result");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_EMIT)
    else $error("step counter left the program");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new sample taken while one is still in work");
`endif

endmodule

// File: rtl/preset_biquad_lowpass_cascade_top.sv
// Preset low-pass filter: four cascaded biquads (8th-order Butterworth),
// transposed direct form II, Q2.30 coefficients, Q24.24 signals.
//
// Channels:
//   s_axis_*  one beat = one unsigned 16-bit raw sample.
//   m_axis_*  one beat = one filtered sample, truncated toward zero and
//             clamped to 0 .. 65535.
//   cfg_*     write of corner_select (preset 0..7). Any write, even of the
//             same value, clears all delay states. Always ready; write only
//             while no sample is in work.
// Timing: a microcoded sequencer runs one shared multiplier, 12 steps per
// biquad stage. The result beat is presented from the output register, and
// a new sample is taken only after the result is handed to that register,
// so the block works on one sample at a time.
// Stall: the result waits in the output register; while it is not taken the
// sequencer can still take and compute the next sample, then holds at its hand-off step.
// Reset: preset 0, delays cleared, output register empty.
module preset_biquad_lowpass_cascade_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bqc_pkg::DATA_W-1:0] s_axis_tdata,   // [15:0] sample_in
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bqc_pkg::DATA_W-1:0] m_axis_tdata,   // [15:0] filtered_out
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bqc_pkg::SET_W-1:0]  corner_select
);
  import bqc_pkg::*;

  logic [SET_W-1:0]  preset;
  logic              clear;
  logic              out_free;
  logic              emit;
  logic [DATA_W-1:0] result;
  dp_ctrl_t          ctrl;

  // Preset register; a write also clears the delays
  assign cfg_ready = 1'b1;
  assign clear     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      preset <= '0;
    end else if (clear) begin
      preset <= corner_select;
    end
  end

  bqc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .emit     (emit),
    .ctrl     (ctrl)
  );

  bqc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .preset (preset),
    .clear  (clear),
    .sample (s_axis_tdata),
    .result (result)
  );

  // Output register
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= result;
    end
  end

endmodule

// File: bench/lowpass_checker.sv
// Watches the sample, result and preset channels of the biquad cascade,
// predicts every filtered sample and compares it with the result beats.
module lowpass_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [bqc_pkg::DATA_W-1:0]   in_sample,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [bqc_pkg::DATA_W-1:0]   out_sample,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [bqc_pkg::SET_W-1:0]    cfg_corner,
  output int                           mismatches,
  output int                           pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import bqc_pkg::*;

  localparam int     TAPS    = COEFS * NUM_STAGES;
  localparam longint SIG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SIG_MIN = -SIG_MAX - 1;
  localparam longint OUT_MAX = (64'sd1 << SAMPLE_BITS) - 1;

  // Decimal coefficient table: value = mantissa * 10^(exponent - 7),
  // per stage b0 b1 b2 a1 a2
  localparam int CORNER_MANT [NUM_PRESETS][TAPS] = '{
    '{15783620, 31567240, 15783620, 19990135, -99901985,
      15769340, 31538680, 15769340, 19972050, -99721130,
      15758428, 31516856, 15758428, 19958230, -99582930,
      15752529, 31505058, 15752529, 19950759, -99508216},
    '{39381354, 78762708, 39381354, 19949514, -99510896,
      39204201, 78408402, 39204201, 19859773, -98613417,
      39069687, 78139374, 39069687, 19791632, -97931951,
      38997273, 77994546, 38997273, 19754949, -97565092},
    '{15713498, 31426996, 15713498, 19896140, -99024256,
      15573111, 31146223, 15573111, 19718385, -97246141,
      15467347, 30934694, 15467347, 19584468, -95906550,
      15410705, 30821409, 15410705, 19512749, -95189129},
    '{97469593, 19493919, 97469593, 19718981, -97579684,
      95337764, 19067553, 95337764, 19287692, -93258273,
      93768096, 18753619, 93768096, 18970134, -90076413,
      92939962, 18587992, 92939962, 18802595, -88397712},
    '{14981559, 29963119, 14981559, 18475297, -90745598,
      13801535, 27603069, 13801535, 17020088, -75721493,
      13016825, 26033650, 13016825, 16052382, -65730554,
      12628246, 25256493, 12628246, 15573186, -60783158},
    '{85667865, 17133573, 85667865, 14515796, -79425105,
      71984525, 14396905, 71984525, 12197254, -50766347,
      64143120, 12828624, 64143120, 10868585, -34343094,
      60572179, 12114436, 60572179, 10263515, -26864019},
    '{29142074, 58284148, 29142074, 52130927, -68699222,
      22605098, 45210196, 22605098, 40437229, -30857621,
      19292853, 38585705, 19292853, 34512104, -11683514,
      17875346, 35750691, 17875346, 31976390, -34777725},
    '{81145766, 16229153, 81145766, -14515796, -79425105,
      68184721, 13636944, 68184721, -12197254, -50766347,
      60757235, 12151447, 60757235, -10868585, -34343094,
      57374792, 11474958, 57374792, -10263515, -26864019}
  };

  localparam int CORNER_EXP [NUM_PRESETS][TAPS] = '{
    '{-6, -6, -6, 0, -1, -6, -6, -6, 0, -1, -6, -6, -6, 0, -1, -6, -6, -6, 0, -1},
    '{-5, -5, -5, 0, -1, -5, -5, -5, 0, -1, -5, -5, -5, 0, -1, -5, -5, -5, 0, -1},
    '{-4, -4, -4, 0, -1, -4, -4, -4, 0, -1, -4, -4, -4, 0, -1, -4, -4, -4, 0, -1},
    '{-4, -3, -4, 0, -1, -4, -3, -4, 0, -1, -4, -3, -4, 0, -1, -4, -3, -4, 0, -1},
    '{-2, -2, -2, 0, -1, -2, -2, -2, 0, -1, -2, -2, -2, 0, -1, -2, -2, -2, 0, -1},
    '{-2, -1, -2, 0, -1, -2, -1, -2, 0, -1, -2, -1, -2, 0, -1, -2, -1, -2, 0, -1},
    '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -2},
    '{-1, 0, -1, 0, -1, -1, 0, -1, 0, -1, -1, 0, -1, 0, -1, -1, 0, -1, 0, -1}
  };

  longint            coef_q30 [NUM_PRESETS][TAPS];
  longint            stage_state [2*NUM_STAGES];
  int unsigned       corner;
  logic [DATA_W-1:0] expected_filtered [$];

  // Q2.30 from decimal, rounded to nearest with ties away from zero
  function automatic longint to_q30(int mant, int expo);
    longint mag;
    longint div;
    mag = (mant < 0) ? -longint'(mant) : longint'(mant);
    div = 1;
    for (int k = 0; k < 7 - expo; k++) div *= 10;
    mag = ((mag << CFRAC) + div / 2) / div;
    return (mant < 0) ? -mag : mag;
  endfunction

  // Exact product, floored back to Q24.24
  function automatic longint scale_q30(longint c, longint v);
    logic signed [95:0] prod;
    prod = c * v;
    return longint'(prod >>> CFRAC);
  endfunction

  function automatic longint clamp48(longint v);
    if (v > SIG_MAX) return SIG_MAX;
    if (v < SIG_MIN) return SIG_MIN;
    return v;
  endfunction

  // Runs one sample through the four sections and updates their delays
  function automatic logic [DATA_W-1:0] filter_sample(logic [DATA_W-1:0] raw);
    longint      x;
    longint      y;
    longint      b0, b1, b2, a1, a2;
    int unsigned set;
    int unsigned base;
    set = (corner >= NUM_PRESETS) ? NUM_PRESETS - 1 : corner;
    x = longint'(raw) << FRAC;
    y = 0;
    for (int s = 0; s < NUM_STAGES; s++) begin
      base = s * COEFS;
      b0 = coef_q30[set][base + int'(CF_B0)];
      b1 = coef_q30[set][base + int'(CF_B1)];
      b2 = coef_q30[set][base + int'(CF_B2)];
      a1 = coef_q30[set][base + int'(CF_A1)];
      a2 = coef_q30[set][base + int'(CF_A2)];
      y = clamp48(scale_q30(b0, x) + stage_state[2*s]);
      stage_state[2*s]   = clamp48(scale_q30(b1, x) + scale_q30(a1, y) + stage_state[2*s+1]);
      stage_state[2*s+1] = clamp48(scale_q30(b2, x) + scale_q30(a2, y));
      x = y;
    end
    // truncate toward zero, clamp to the unsigned output range
    if (y < 0) return '0;
    if ((y >>> FRAC) > OUT_MAX) return DATA_W'(OUT_MAX);
    return DATA_W'(y >>> FRAC);
  endfunction

  initial begin
    for (int p = 0; p < NUM_PRESETS; p++)
      for (int t = 0; t < TAPS; t++)
        coef_q30[p][t] = to_q30(CORNER_MANT[p][t], CORNER_EXP[p][t]);
  end

  // Result beats are matched before the sample beat of the same edge
  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst) begin
      corner = 0;
      foreach (stage_state[i]) stage_state[i] = 0;
      expected_filtered.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        corner = cfg_corner;
        foreach (stage_state[i]) stage_state[i] = 0;
      end
      if (out_valid && out_ready) begin
        if (expected_filtered.size() == 0) begin
          $display("%0t: result beat %0d with no sample pending", $time, out_sample);
          mismatches++;
        end else begin
          want = expected_filtered.pop_front();
          if (out_sample !== want) begin
            $display("%0t: filtered_out expected %0d, got %0d", $time, want, out_sample);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_filtered.push_back(filter_sample(in_sample));
    end
    pending_results = expected_filtered.size();
  end

endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bqc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          RANDOM_PER_CORNER = 83;
  localparam int          LONG_HOLD_SEGMENT = 250;
  localparam int          LONG_HOLD_CYCLES  = 600;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;    // [15:0] sample_in
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;    // [15:0] filtered_out
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SET_W-1:0]  corner_select;

  int                mismatches;
  int                pending_results;
  logic              draining = 1'b0;
  int                burst_left = 0;
  logic [DATA_W-1:0] random_level = '0;
  int unsigned       cycle_count = 0;

  // Ringing test at the widest corner: full-scale steps both ways
  localparam logic [DATA_W-1:0] RING_SEQ [20] = '{
    16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0
  };
  localparam logic [SET_W-1:0] CORNER_PLAN [10] = '{
    3'd0, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4, 3'd7, 3'd0, 3'd7
  };

  always #5 clk = ~clk;

  preset_biquad_lowpass_cascade_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .corner_select (corner_select)
  );

  lowpass_checker chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_sample       (s_axis_tdata),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_sample      (m_axis_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_corner      (corner_select),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  // Sample beat, sent in bursts with random gaps between them
  task automatic offer_sample(logic [DATA_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_corner(logic [SET_W-1:0] value);
    cfg_valid     <= 1'b1;
    corner_select <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly held levels (steps), with jumps, extremes and noise
  function automatic logic [DATA_W-1:0] next_sensor_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      random_level = $urandom_range(0, 1) ? '1 : '0;
    else if (pick < 20)
      random_level = DATA_W'($urandom());
    if (pick < 60) return random_level;
    if (pick < 80) return random_level ^ DATA_W'($urandom_range(0, 255));
    return DATA_W'($urandom());
  endfunction

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: stall pattern of its own, one long hold-off
  initial begin
    int seg_len;
    int mode;
    int segs;
    m_axis_tready = 1'b0;
    segs = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      segs++;
      if (segs == LONG_HOLD_SEGMENT) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else begin
        seg_len = $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        repeat (seg_len) begin
          m_axis_tready <= draining || mode == 0 || (mode >= 2 && $urandom_range(0, 1) == 1);
          @(negedge clk);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    corner_select = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset corner: full-scale step up and down
    offer_sample(16'hFFFF);
    offer_sample(16'd0);
    drain_results();

    // overshoot and undershoot at the widest corner
    write_corner(3'd7);
    foreach (RING_SEQ[i]) offer_sample(RING_SEQ[i]);
    drain_results();

    // rewriting the same corner must clear the delays
    write_corner(3'd7);
    offer_sample(16'hFFFF);
    offer_sample(16'hFFFF);

    foreach (CORNER_PLAN[p]) begin
      drain_results();
      write_corner(CORNER_PLAN[p]);
      repeat (RANDOM_PER_CORNER) offer_sample(next_sensor_sample());
    end
    drain_results();

    draining <= 1'b1;
    repeat (60) @(negedge clk);
    if (mismatches == 0 && pending_results == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
